FILE: sv/cmb_pkg.sv
// Shared types and constants of the cross mean blur block.
// No dependencies; every file of the block but cmb_ram imports this package.
`default_nettype none

package cmb_pkg;

	// Channel and register geometry
	localparam int CH_W           = 8;
	localparam int NCH            = 4;
	localparam int PIX_W          = CH_W * NCH;
	localparam int CFG_W          = 9;
	localparam int CFG_IDX_W      = 2;
	localparam int WIDTH_RESET    = 120;
	localparam int HEIGHT_RESET   = 68;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// Line banks, neighborhood and per-channel sums
	localparam int NBANK    = 3;
	localparam int MAX_TAPS = 5;
	localparam int CNT_W    = $clog2(MAX_TAPS + 1);
	localparam int SUM_W    = CH_W + $clog2(MAX_TAPS);

	// Queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		action_t           action;
		logic [CH_W-1:0]   red_in;
		logic [CH_W-1:0]   green_in;
		logic [CH_W-1:0]   blue_in;
		logic [CH_W-1:0]   alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [CH_W-1:0]   red_out;
		logic [CH_W-1:0]   green_out;
		logic [CH_W-1:0]   blue_out;
		logic [CH_W-1:0]   alpha_out;
		logic              frame_end;
	} pixel_out_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

	// One pending result: channel sums, number of taps, end-of-frame mark
	typedef struct packed {
		logic [NCH-1:0][SUM_W-1:0] sum;
		logic [CNT_W-1:0]          count;
		logic                      frame_end;
	} job_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              nonempty;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: sv/cmb_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// A read at the address being written returns the previous contents.
`default_nettype none

module cmb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read in the same edge; reads see the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: sv/cmb_front.sv
// Front of the cross mean blur: accepts items, tracks frame positions, keeps
// the three line banks and forms the channel sums. Uses cmb_pkg and cmb_ram.
`default_nettype none

module cmb_front import cmb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      pix_valid,
	input  wire pixel_in_t pix,
	output logic           pix_stall,
	input  wire cfg_wr_t   cfg,
	input  wire q_stat_t   q_stat,
	output logic           push,
	output job_t           push_job
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int LAG_W  = $clog2(MAX_WIDTH + 2);
	localparam int CMP_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 2;
	localparam int RCMP_W = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 2;

	function automatic logic [1:0] nxt_bank(input logic [1:0] b);
		nxt_bank = (b == 2'(NBANK - 1)) ? 2'd0 : b + 2'd1;
	endfunction

	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] w_eff, h_eff;

	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [1:0]       in_bank_q, out_bank_q;
	logic             in_done_q;
	logic [LAG_W-1:0] lag_q;

	logic             valid_s1;
	logic [1:0]       mid_s1, above_s1, below_s1;
	logic             left_ok_s1, right_ok_s1, up_ok_s1, down_ok_s1;
	logic [CNT_W-1:0] count_s1;
	logic             frame_end_s1;
	logic [PIX_W-1:0] left_pix_q;

	logic             accept, is_drain, emit, wr, restart, cfg_hit;
	logic             col_last_o, row_last_o, col_last_i, row_last_i, lag_full, frame_last;
	logic [PIX_W-1:0] pix_word;
	logic [PIX_W-1:0] rd_a [NBANK];
	logic [PIX_W-1:0] rd_b [NBANK];
	logic [PIX_W-1:0] center, right_pix, above_pix, below_pix;

	// Clamp the frame size to the supported range
	always_comb begin
		if (width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Classify the item at the input
	assign pix_stall  = (int'(q_stat.level) + int'(valid_s1)) >= QDEPTH;
	assign accept     = pix_valid && !pix_stall;
	assign is_drain   = (pix.action == ACT_DRAIN);
	assign col_last_o = (CMP_W'(out_col_q) + CMP_W'(1)) == CMP_W'(w_eff);
	assign row_last_o = (RCMP_W'(out_row_q) + RCMP_W'(1)) == RCMP_W'(h_eff);
	assign col_last_i = (CMP_W'(in_col_q) + CMP_W'(1)) == CMP_W'(w_eff);
	assign row_last_i = (RCMP_W'(in_row_q) + RCMP_W'(1)) == RCMP_W'(h_eff);
	assign lag_full   = CMP_W'(lag_q) == (CMP_W'(w_eff) + CMP_W'(1));
	assign frame_last = col_last_o && row_last_o;
	assign emit       = accept && (is_drain ? in_done_q : (!in_done_q && lag_full));
	assign wr         = accept && !is_drain && !in_done_q;
	assign cfg_hit    = cfg.valid && ((cfg.index == REG_FRAME_WIDTH) ||
	                                  (cfg.index == REG_FRAME_HEIGHT));
	assign restart    = cfg_hit || (emit && frame_last);
	assign pix_word   = {pix.alpha_in, pix.blue_in, pix.green_in, pix.red_in};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(WIDTH_RESET);
			height_q <= CFG_W'(HEIGHT_RESET);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data;
				REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance input and output positions; restart at frame end or on reconfig
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_bank_q  <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_bank_q <= '0;
			lag_q      <= '0;
		end else if (restart) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_bank_q  <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_bank_q <= '0;
			lag_q      <= '0;
		end else begin
			if (emit) begin
				if (col_last_o) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ROW_W'(1);
					out_bank_q <= nxt_bank(out_bank_q);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			if (wr) begin
				if (col_last_i) begin
					in_col_q <= '0;
					if (row_last_i) begin
						in_done_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + ROW_W'(1);
						in_bank_q <= nxt_bank(in_bank_q);
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (wr && !emit) begin
				lag_q <= lag_q + LAG_W'(1);
			end else if (!wr && emit) begin
				lag_q <= lag_q - LAG_W'(1);
			end
		end
	end

	// Line banks: row r lives in bank r mod 3; reads see the pre-write word
	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		cmb_ram #(
			.WIDTH (PIX_W),
			.DEPTH (MAX_WIDTH)
		) u_bank (
			.clk     (clk),
			.we      (wr && (in_bank_q == 2'(b))),
			.waddr   (in_col_q),
			.wdata   (pix_word),
			.re      (emit),
			.raddr_a (out_col_q),
			.raddr_b (out_col_q + COL_W'(1)),
			.rdata_a (rd_a[b]),
			.rdata_b (rd_b[b])
		);
	end

	// Capture the neighborhood shape while the banks are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mid_s1       <= out_bank_q;
			below_s1     <= nxt_bank(out_bank_q);
			above_s1     <= nxt_bank(nxt_bank(out_bank_q));
			left_ok_s1   <= (out_col_q != '0);
			right_ok_s1  <= !col_last_o;
			up_ok_s1     <= (out_row_q != '0);
			down_ok_s1   <= !row_last_o;
			count_s1     <= CNT_W'(1) + CNT_W'(out_col_q != '0) + CNT_W'(!col_last_o)
			              + CNT_W'(out_row_q != '0) + CNT_W'(!row_last_o);
			frame_end_s1 <= frame_last;
		end
		// Keep the previous center as the left tap of the next result
		if (valid_s1) begin
			left_pix_q <= center;
		end
	end

	// Sum the taps that lie inside the frame
	assign center    = rd_a[mid_s1];
	assign right_pix = rd_b[mid_s1];
	assign above_pix = rd_a[above_s1];
	assign below_pix = rd_a[below_s1];

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			push_job.sum[k] = SUM_W'(center[k*CH_W +: CH_W])
				+ (left_ok_s1  ? SUM_W'(left_pix_q[k*CH_W +: CH_W]) : SUM_W'(0))
				+ (right_ok_s1 ? SUM_W'(right_pix[k*CH_W +: CH_W])  : SUM_W'(0))
				+ (up_ok_s1    ? SUM_W'(above_pix[k*CH_W +: CH_W])  : SUM_W'(0))
				+ (down_ok_s1  ? SUM_W'(below_pix[k*CH_W +: CH_W])  : SUM_W'(0));
		end
		push_job.count     = count_s1;
		push_job.frame_end = frame_end_s1;
	end

	assign push = valid_s1;

`ifndef SYNTHESIS
	// Pending outputs never exceed one row plus one pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(lag_q) <= (CMP_W'(w_eff) + CMP_W'(1)))
		else $error("front: pending count beyond one row plus one");
	// The last result of a frame only comes from a drain
	assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !(emit && frame_last))
		else $error("front: frame end on a pixel write");
`endif

endmodule

`default_nettype wire

FILE: sv/cmb_queue.sv
// Short job queue between the front and the back of the cross mean blur.
// Uses cmb_pkg for the job type and depth.
`default_nettype none

module cmb_queue import cmb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_stat_t   q_stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head           = mem_q[rd_ptr_q];
	assign q_stat.level    = count_q;
	assign q_stat.nonempty = (count_q != '0);

`ifndef SYNTHESIS
	// Front admission must leave room for every job in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_W'(QDEPTH)) || pop)
		else $error("queue: push into a full queue");
`endif

endmodule

`default_nettype wire

FILE: sv/cmb_back.sv
// Back of the cross mean blur: divides the channel sums by the tap count
// and holds the result register. Uses cmb_pkg.
`default_nettype none

module cmb_back import cmb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t q_stat,
	input  wire job_t    head,
	output logic         pop,
	output logic         res_valid,
	input  wire logic    res_stall,
	output pixel_out_t   res
);

	localparam int RECIP_SH = 13;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;

	// Rounded-up reciprocal of the tap count; exact for sums of up to five taps
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			CNT_W'(1): r = RECIP_W'(1 << RECIP_SH);
			CNT_W'(2): r = RECIP_W'((1 << RECIP_SH) / 2);
			CNT_W'(3): r = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
			CNT_W'(4): r = RECIP_W'((1 << RECIP_SH) / 4);
			CNT_W'(5): r = RECIP_W'(((1 << RECIP_SH) + 4) / 5);
			default:   r = RECIP_W'(1 << RECIP_SH);
		endcase
		return r;
	endfunction

	logic                  res_valid_q;
	pixel_out_t            res_q;
	logic [RECIP_W-1:0]    recip;
	logic [PROD_W-1:0]     prod [NCH];
	logic [NCH-1:0][CH_W-1:0] mean;

	// Take the next job when the result register is free or being taken
	assign pop = q_stat.nonempty && (!res_valid_q || !res_stall);

	// Divide by multiplying with the reciprocal
	always_comb begin
		recip = recip_of(head.count);
		for (int k = 0; k < NCH; k++) begin
			prod[k] = PROD_W'(head.sum[k]) * PROD_W'(recip);
			mean[k] = prod[k][RECIP_SH +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.red_out   <= mean[0];
			res_q.green_out <= mean[1];
			res_q.blue_out  <= mean[2];
			res_q.alpha_out <= mean[3];
			res_q.frame_end <= head.frame_end;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// Every job carries between one and five taps
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head.count != '0) && (head.count <= CNT_W'(MAX_TAPS)))
		else $error("back: tap count out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/cross_mean_blur_rgba.sv
// Top level of the five-point cross mean blur for an RGBA8888 raster stream.
// Uses cmb_pkg, cmb_front, cmb_queue and cmb_back.
`default_nettype none

// The block takes one item per clock, pixels and drains alike. A result
// passes through the bank read stage, job queue and result register; pixel
// results trail their inputs by one row plus one pixel, and
// the drain items after the frame flush the rest. The input stalls only when
// the four-entry job queue between the line-bank front and the divider back
// has filled because the output is stalled. Line storage is three banks of
// MAX_WIDTH 32-bit words, each with one write port and two read ports; the
// banks need no clearing pass after reset. Configuration writes are always
// taken; a write to either frame size register restarts the frame, a write
// to any other index is dropped.
module cross_mean_blur_rgba import cmb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pix_valid,
	output logic                      pix_stall,
	input  wire pixel_in_t            pix,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output pixel_out_t                res,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	cfg_wr_t cfg;
	q_stat_t q_stat;
	logic    push, pop;
	job_t    push_job, head;

	// Register writes are taken in any cycle
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	cmb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_stall (pix_stall),
		.cfg       (cfg),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	cmb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	cmb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for cross_mean_blur_rgba: random RGBA frames, checked against a predictor.
// Depends on cmb_pkg and the cross_mean_blur_rgba RTL; needs no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cmb_pkg::*;

	localparam int LINE_MAX      = MAX_WIDTH_DEF;
	localparam int ROWS_MAX      = MAX_HEIGHT_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int ITEM_TARGET   = 1000;
	localparam int HOLD_CYCLES   = 90;
	localparam int HOLD_AFTER    = 60;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 pix_valid = 1'b0;
	logic                 pix_stall;
	pixel_in_t            pix = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	pixel_out_t           res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	cross_mean_blur_rgba dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: line banks, sizes and raster positions
	logic [PIX_W-1:0] line_bank [NBANK][LINE_MAX];
	logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
	logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
	int unsigned      in_col, in_row, out_col, out_row;

	pixel_out_t  expected_pixels [$];
	pixel_in_t   pending_items [$];
	bit          pix_taken;
	bit          calm;
	int unsigned fail_count, results_seen, quiet_cycles, items_sent;

	function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned top);
		if (v == '0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Average the in-frame cross around the next output position, then advance it
	function automatic pixel_out_t blur_next(int unsigned w, int unsigned h);
		int unsigned      r, c, taps;
		int unsigned      sum [NCH];
		logic [PIX_W-1:0] nb [MAX_TAPS];
		pixel_out_t       o;
		r = out_row;
		c = out_col;
		nb[0] = line_bank[r % NBANK][c];
		taps = 1;
		if (c > 0) begin
			nb[taps] = line_bank[r % NBANK][c - 1];
			taps++;
		end
		if (c + 1 < w) begin
			nb[taps] = line_bank[r % NBANK][c + 1];
			taps++;
		end
		if (r > 0) begin
			nb[taps] = line_bank[(r + 2) % NBANK][c];
			taps++;
		end
		if (r + 1 < h) begin
			nb[taps] = line_bank[(r + 1) % NBANK][c];
			taps++;
		end
		for (int k = 0; k < NCH; k++)
			sum[k] = 0;
		for (int p = 0; p < taps; p++)
			for (int k = 0; k < NCH; k++)
				sum[k] += nb[p][CH_W*k +: CH_W];
		o.red_out   = CH_W'(sum[0] / taps);
		o.green_out = CH_W'(sum[1] / taps);
		o.blue_out  = CH_W'(sum[2] / taps);
		o.alpha_out = CH_W'(sum[3] / taps);
		if (r + 1 == h && c + 1 == w) begin
			o.frame_end = 1'b1;
			restart_frame();
		end else begin
			o.frame_end = 1'b0;
			out_col = c + 1;
			if (out_col >= w) begin
				out_col = 0;
				out_row = r + 1;
			end
		end
		return o;
	endfunction

	// Work out what one accepted transaction produces
	function automatic void blur_predict(pixel_in_t item);
		int unsigned w, h, got, made;
		w = clamp_size(width_reg, LINE_MAX);
		h = clamp_size(height_reg, ROWS_MAX);
		if (in_col >= w)
			in_col = 0;
		if (out_col >= w)
			out_col = 0;
		if (item.action == ACT_DRAIN) begin
			if (in_row >= h && out_row < h)
				expected_pixels.push_back(blur_next(w, h));
			return;
		end
		if (in_row >= h)
			return;
		got = in_row * w + in_col;
		made = out_row * w + out_col;
		if (got - made == w + 1)
			expected_pixels.push_back(blur_next(w, h));
		line_bank[in_row % NBANK][in_col] =
			{item.alpha_in, item.blue_in, item.green_in, item.red_in};
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
	endfunction

	function automatic void reg_write_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = val;
			restart_frame();
		end else if (idx == REG_FRAME_HEIGHT) begin
			height_reg = val;
			restart_frame();
		end
	endfunction

	function automatic void check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Pick an idling rate for the next stretch; zero means no idling
	function automatic int unsigned pick_odds();
		case ($urandom_range(2, 0))
			0: return 0;
			1: return 2;
			default: return 6;
		endcase
	endfunction

	// Sample both channels, predict, check, and watch for a hang
	always @(posedge clk) begin
		pixel_out_t want;
		bit         moved;
		pix_taken = pix_valid && !pix_stall;
		moved = pix_taken || (cfg_valid && cfg_ready);
		if (pix_taken)
			blur_predict(pix);
		if (arst_n && res_valid && !res_stall) begin
			moved = 1'b1;
			results_seen++;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, res);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("red_out", want.red_out, res.red_out);
				check_field("green_out", want.green_out, res.green_out);
				check_field("blue_out", want.blue_out, res.blue_out);
				check_field("alpha_out", want.alpha_out, res.alpha_out);
				check_field("frame_end", want.frame_end, res.frame_end);
			end
		end
		if (moved)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Pixel driver: hold the payload until taken, insert random gaps
	int unsigned send_gap, send_odds, send_tick;
	always @(negedge clk) begin
		logic      next_valid;
		pixel_in_t next_item;
		next_valid = pix_valid;
		next_item = pix;
		if (pix_taken)
			next_valid = 1'b0;
		send_tick++;
		if (send_tick % 50 == 0)
			send_odds = pick_odds();
		if (!next_valid && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				next_valid = 1'b1;
				if (!calm && send_odds > 0 && $urandom_range(send_odds - 1, 0) == 0)
					send_gap = $urandom_range(5, 1);
			end
		end
		pix_valid <= next_valid;
		pix <= next_item;
	end

	// Result stall: random bursts, plus one long hold to back the block up
	int unsigned hold_left, stall_left, stall_odds, stall_tick;
	bit          hold_done;
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 50 == 25)
			stall_odds = pick_odds();
		if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
			if (!calm && stall_odds > 0 && $urandom_range(stall_odds - 1, 0) == 0)
				stall_left = $urandom_range(5, 1);
		end
	end

	function automatic logic [PIX_W-1:0] random_rgba();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_pixel(logic [PIX_W-1:0] rgba);
		pixel_in_t it;
		it.action = ACT_PIXEL;
		{it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
		pending_items.push_back(it);
	endtask

	task automatic queue_drain();
		pixel_in_t it;
		it.action = ACT_DRAIN;
		{it.alpha_in, it.blue_in, it.green_in, it.red_in} = $urandom;
		pending_items.push_back(it);
	endtask

	// One full frame with occasional early drains and, at times, a stray pixel at the end
	task automatic queue_frame(int unsigned w, int unsigned h);
		int unsigned total;
		total = w * h;
		for (int unsigned i = 0; i < total; i++) begin
			if ($urandom_range(15, 0) == 0)
				queue_drain();
			queue_pixel(random_rgba());
		end
		if ($urandom_range(3, 0) == 0)
			queue_pixel(random_rgba());
		repeat (w + 1 + $urandom_range(1, 0))
			queue_drain();
		items_sent += total + w + 1;
	endtask

	// Wait until every transaction is through and every result is back
	task automatic settle();
		while (pending_items.size() != 0 || pix_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		reg_write_apply(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val, int unsigned frames);
		write_reg(REG_FRAME_WIDTH, w_val);
		write_reg(REG_FRAME_HEIGHT, h_val);
		repeat (frames)
			queue_frame(clamp_size(w_val, LINE_MAX), clamp_size(h_val, ROWS_MAX));
	endtask

	initial begin
		logic [CFG_W-1:0] w_val, h_val;
		int unsigned      cut;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset sizes: early drains and extreme pixels, too few for any result
		queue_drain();
		queue_pixel('0);
		queue_pixel('1);
		queue_pixel(32'h00FF00FF);
		queue_pixel(32'hFF00FF00);
		queue_drain();

		// Tiny 3x2 frame of extremes; the stray pixel after it is ignored
		write_reg(REG_FRAME_WIDTH, 9'd3);
		write_reg(REG_FRAME_HEIGHT, 9'd2);
		queue_pixel('1);
		queue_pixel('0);
		queue_pixel('1);
		queue_pixel('0);
		queue_pixel('1);
		queue_pixel(32'h80808080);
		queue_pixel('1);
		repeat (5) queue_drain();

		// Zero sizes act as a single pixel frame
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '0);
		queue_pixel(random_rgba());
		queue_drain();
		queue_drain();

		// Unused register index: no effect, frame carries on
		write_reg(REG_SPARE, '1);
		queue_pixel(random_rgba());
		queue_drain();

		// Largest sizes, once each, then an abandoned frame at the clamped width
		run_phase(9'd256, 9'd1, 1);
		run_phase(9'd1, 9'h1FF, 1);
		write_reg(REG_FRAME_WIDTH, 9'h1FF);
		write_reg(REG_FRAME_HEIGHT, 9'd3);
		repeat (20) queue_pixel(random_rgba());

		// Random small frames, now and then cut short
		while (items_sent < ITEM_TARGET) begin
			if (!calm && items_sent + 150 >= ITEM_TARGET) begin
				@(posedge clk);
				calm = 1'b1;
			end
			w_val = CFG_W'($urandom_range(12, 1));
			h_val = CFG_W'($urandom_range(8, 1));
			case ($urandom_range(11, 0))
				0: w_val = '0;
				1: h_val = '0;
				2: w_val = CFG_W'($urandom_range(40, 13));
				default: ;
			endcase
			run_phase(w_val, h_val, $urandom_range(3, 1));
			if ($urandom_range(7, 0) == 0) begin
				cut = $urandom_range(clamp_size(w_val, LINE_MAX) * clamp_size(h_val, ROWS_MAX), 1);
				repeat (cut) queue_pixel(random_rgba());
				items_sent += cut;
			end
		end

		settle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
